// File: design/plmr_pkg.sv
// ----------------------------------------------------------------------------
// plmr_pkg: shared types and constants for the face reconstruction core
// Sample and limiter widths, and the tag that travels down the pipeline.
// ----------------------------------------------------------------------------
package plmr_pkg;

  // signed sample width and unsigned limiter steepness width
  localparam int SAMPLE_W  = 32;
  localparam int THETA_W   = 18;
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int IN_DATA_W = 3 * SAMPLE_W;

  // per-item control and bypass data carried alongside the slope magnitudes
  typedef struct packed {
    logic                valid;
    logic                active;
    logic                neg;
    logic [SAMPLE_W-1:0] mid;
  } tag_t;

endpackage

// File: design/plmr_limiter.sv
// ----------------------------------------------------------------------------
// plmr_limiter: limiter candidates and their minimum
// Two register stages: theta*a, (a+b)/2 and theta*b, then the smallest.
// ----------------------------------------------------------------------------
module plmr_limiter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  plmr_pkg::tag_t                   tag_in,
  input  logic [plmr_pkg::MAG_W-1:0]       a,
  input  logic [plmr_pkg::MAG_W-1:0]       b,
  input  logic [plmr_pkg::THETA_W-1:0]     theta,
  output plmr_pkg::tag_t                   tag_out,
  output logic [((plmr_pkg::THETA_W + plmr_pkg::MAG_W) > (plmr_pkg::MAG_W + FRAC_BITS)
                 ? (plmr_pkg::THETA_W + plmr_pkg::MAG_W)
                 : (plmr_pkg::MAG_W + FRAC_BITS))-1:0] m
);

  localparam int PW = plmr_pkg::THETA_W + plmr_pkg::MAG_W;
  localparam int HW = plmr_pkg::MAG_W + FRAC_BITS;
  localparam int MW = (PW > HW) ? PW : HW;

  plmr_pkg::tag_t tag_p;
  logic [MW-1:0]  c1;
  logic [MW-1:0]  c2;
  logic [MW-1:0]  c3;
  logic [plmr_pkg::MAG_W:0] sum_ab;
  logic           lt12;
  logic           lt13;
  logic           lt23;
  logic [MW-1:0]  m_next;

  // candidate products and the half sum scaled to the product format
  assign sum_ab = (plmr_pkg::MAG_W+1)'(a) + (plmr_pkg::MAG_W+1)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= MW'(theta) * MW'(a);
      c2 <= MW'(sum_ab) << (FRAC_BITS - 1);
      c3 <= MW'(theta) * MW'(b);
    end
  end

  // minimum of three from parallel compares
  assign lt12 = c1 < c2;
  assign lt13 = c1 < c3;
  assign lt23 = c2 < c3;

  always_comb begin
    if (lt12 && lt13) begin
      m_next = c1;
    end else if (!lt12 && lt23) begin
      m_next = c2;
    end else begin
      m_next = c3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m <= m_next;
    end
  end

  // tag follows the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p.valid   <= 1'b0;
      tag_out.valid <= 1'b0;
    end else if (en) begin
      tag_p.valid   <= tag_in.valid;
      tag_out.valid <= tag_p.valid;
    end
    if (en) begin
      tag_p.active   <= tag_in.active;
      tag_p.neg      <= tag_in.neg;
      tag_p.mid      <= tag_in.mid;
      tag_out.active <= tag_p.active;
      tag_out.neg    <= tag_p.neg;
      tag_out.mid    <= tag_p.mid;
    end
  end

endmodule

// File: design/plm_limited_face_reconstruction_core.sv
// ----------------------------------------------------------------------------
// plm_limited_face_reconstruction_core: limited linear face reconstruction
// Generalized minmod limited face value from three neighboring cell samples.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one beat per stencil, s_tdata = {next, mid, prev} with prev in
//   the lowest 32 bits, s_tuser[0] = face side (0 right face, 1 left face).
//   m_* channel: one beat per stencil, the saturated face value in Q format.
//   cfg_* channel: writes the limiter steepness theta; cfg_ready is always
//   high, write only while no beat is in flight.
// Timing
//   Four register stages: slope magnitudes, limiter candidates, their
//   minimum, then rounding/add/clamp into the output register. A beat taken
//   at edge n passes these registers in order to m_*; one beat per cycle unless m_tready stalls the output.
// Reset and stall
//   rst (synchronous) empties the pipeline and sets theta to 2.0.
//   When the receiver holds m_tready low with a beat pending, the whole
//   pipeline holds; s_tready drops and nothing is lost or repeated. Bubbles
//   ahead of the output register still move while it is empty.
// ----------------------------------------------------------------------------
module plm_limited_face_reconstruction_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // stencil input
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [plmr_pkg::IN_DATA_W-1:0]     s_tdata,  // sample_prev, sample_mid, sample_next
  input  logic [0:0]                         s_tuser,  // face_side
  // face value output
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [plmr_pkg::SAMPLE_W-1:0]      m_tdata,  // face_value
  // limiter theta write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [plmr_pkg::THETA_W-1:0]       cfg_data
);

  localparam int SW = plmr_pkg::SAMPLE_W;
  localparam int AW = plmr_pkg::MAG_W;
  localparam int PW = plmr_pkg::THETA_W + plmr_pkg::MAG_W;
  localparam int HW = plmr_pkg::MAG_W + FRAC_BITS;
  localparam int MW = (PW > HW) ? PW : HW;
  localparam int OW = MW - FRAC_BITS;
  localparam int RW = OW + 2;
  localparam logic [63:0] THETA_RST_FULL = 64'd2 << FRAC_BITS;
  localparam logic [plmr_pkg::THETA_W-1:0] THETA_RST = THETA_RST_FULL[plmr_pkg::THETA_W-1:0];

  logic                         en;
  logic [plmr_pkg::THETA_W-1:0] theta;

  logic [SW-1:0]        in_prev;
  logic [SW-1:0]        in_mid;
  logic [SW-1:0]        in_next;
  logic signed [AW-1:0] dl;
  logic signed [AW-1:0] dr;

  plmr_pkg::tag_t t1;
  logic [AW-1:0]  a;
  logic [AW-1:0]  b;
  plmr_pkg::tag_t t3;
  logic [MW-1:0]  m;

  logic [MW:0]           rnd;
  logic [OW-1:0]         off;
  logic signed [RW-1:0]  off_ext;
  logic signed [RW-1:0]  mid_ext;
  logic signed [RW-1:0]  res;
  logic [RW-SW:0]        res_hi;
  logic [SW-1:0]         face_next;

  // the whole pipeline moves unless a held result waits
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // theta register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      theta <= THETA_RST;
    end else if (cfg_valid && cfg_ready) begin
      theta <= cfg_data;
    end
  end

  // stage 1: one-sided differences, magnitudes and the limiter enable
  assign in_prev = s_tdata[SW-1:0];
  assign in_mid  = s_tdata[2*SW-1:SW];
  assign in_next = s_tdata[3*SW-1:2*SW];
  assign dl = $signed({in_mid[SW-1], in_mid}) - $signed({in_prev[SW-1], in_prev});
  assign dr = $signed({in_next[SW-1], in_next}) - $signed({in_mid[SW-1], in_mid});

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
    end else if (en) begin
      t1.valid <= s_tvalid;
    end
    if (en) begin
      a         <= dl[AW-1] ? AW'(-dl) : AW'(dl);
      b         <= dr[AW-1] ? AW'(-dr) : AW'(dr);
      t1.active <= (dl != '0) && (dr != '0) && (dl[AW-1] == dr[AW-1]);
      t1.neg    <= dr[AW-1] ^ s_tuser[0];
      t1.mid    <= in_mid;
    end
  end

  // stages 2 and 3: limiter candidates and their minimum
  plmr_limiter #(
    .FRAC_BITS(FRAC_BITS)
  ) u_limiter (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .tag_in (t1),
    .a      (a),
    .b      (b),
    .theta  (theta),
    .tag_out(t3),
    .m      (m)
  );

  // stage 4: round half of the limited slope, apply sign, add, clamp
  assign rnd     = {1'b0, m} + ((MW+1)'(1) << FRAC_BITS);
  assign off     = rnd[MW:FRAC_BITS+1];
  assign off_ext = $signed(RW'(off));
  assign mid_ext = $signed({{(RW-SW){t3.mid[SW-1]}}, t3.mid});
  assign res     = t3.neg ? (mid_ext - off_ext) : (mid_ext + off_ext);
  assign res_hi  = res[RW-1:SW-1];

  always_comb begin
    if (!t3.active) begin
      face_next = t3.mid;
    end else if ((res_hi == '0) || (res_hi == '1)) begin
      face_next = res[SW-1:0];
    end else if (res[RW-1]) begin
      face_next = {1'b1, {(SW-1){1'b0}}};
    end else begin
      face_next = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= t3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= face_next;
    end
  end

  // a beat leaving the last stage lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    (!rst && en && t3.valid) |=> m_tvalid)
    else $error("valid beat lost at the output register");

  // an item with flat or opposite slopes returns its middle sample
  assert property (@(posedge clk) disable iff (rst)
    (!rst && en && t3.valid && !t3.active) |=> (m_tdata == $past(t3.mid)))
    else $error("unlimited item did not return the middle sample");

  // a stall freezes the stage 1, stage 3 and output valid bits
  assert property (@(posedge clk) disable iff (rst)
    (!rst && !en) |=> $stable({t1.valid, t3.valid, m_tvalid}))
    else $error("pipeline moved during a stall");

endmodule
